// ===== rtl/bbuart_pkg.sv =====
// Shared types and constants for the bit-banged UART string transmitter.
// Used by bbuart_core and bitbang_uart_string_transmitter; no dependencies.
package bbuart_pkg;

  // Depth of the character buffer in bytes.
  localparam int unsigned BUF_DEPTH = 32;
  localparam int unsigned BUF_AW    = $clog2(BUF_DEPTH);

  // Bit times per frame after the start bit: eight data bits and a stop bit.
  localparam logic [3:0] FRAME_BITS = 4'd9;
  localparam logic [7:0] FIRST_MASK = 8'h01;

  // Buffer depth as a send length, used for saturation and range checks.
  localparam logic [8:0] DEPTH_LEN = 9'(BUF_DEPTH);

  // Item kinds carried on the input channel's tuser.
  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_START = 2'd1,
    KIND_TICK  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  // One registered input item.
  typedef struct packed {
    kind_t      kind;
    logic [4:0] byte_index;
    logic [7:0] byte_value;
    logic [5:0] send_length;
    logic       power_level;
  } item_t;

  // One result item, produced for tick items only.
  typedef struct packed {
    logic tx_line;
    logic power_pin;
    logic sending;
  } result_t;

endpackage

// ===== rtl/bbuart_core.sv =====
// Frame sequencer and character buffer of the bit-banged UART transmitter.
// Depends on bbuart_pkg for the item and result types.
module bbuart_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  bbuart_pkg::item_t   item,
  output logic                res_valid,
  output bbuart_pkg::result_t res
);

  // Character buffer, no reset: entries are defined once written.
  logic [7:0] char_store [bbuart_pkg::BUF_DEPTH];

  logic [3:0] bits_left_r, bits_left_nxt;
  logic [7:0] current_char_r, current_char_nxt;
  logic [7:0] bit_mask_r, bit_mask_nxt;
  logic [5:0] next_position_r, next_position_nxt;
  logic [5:0] pending_length_r, pending_length_nxt;
  logic       power_hold_r, power_hold_nxt;
  logic [7:0] store_rd_r;
  logic [5:0] rd_addr;
  logic       store_we;

  // The read port follows the position that the next tick may load.
  assign rd_addr  = !rst_n ? '0 : (fire ? next_position_nxt : next_position_r);
  assign store_we = fire && (item.kind == bbuart_pkg::KIND_WRITE) &&
                    (9'(item.byte_index) < bbuart_pkg::DEPTH_LEN);

  // Buffer write port, and a registered read of the entry at the next position.
  // A write to that same entry is passed straight to the read register.
  always_ff @(posedge clk) begin
    if (store_we) begin
      char_store[item.byte_index[bbuart_pkg::BUF_AW-1:0]] <= item.byte_value;
    end
    if (store_we && (item.byte_index == rd_addr[bbuart_pkg::BUF_AW-1:0])) begin
      store_rd_r <= item.byte_value;
    end else begin
      store_rd_r <= char_store[rd_addr[bbuart_pkg::BUF_AW-1:0]];
    end
  end

  // Next state and result for the item in the input register.
  always_comb begin
    bits_left_nxt      = bits_left_r;
    current_char_nxt   = current_char_r;
    bit_mask_nxt       = bit_mask_r;
    next_position_nxt  = next_position_r;
    pending_length_nxt = pending_length_r;
    power_hold_nxt     = power_hold_r;
    res_valid          = 1'b0;
    res                = '0;
    unique case (item.kind)
      bbuart_pkg::KIND_START: begin
        // A start during a send is dropped; long lengths saturate.
        if (pending_length_r == '0) begin
          if (9'(item.send_length) > bbuart_pkg::DEPTH_LEN) begin
            pending_length_nxt = 6'(bbuart_pkg::BUF_DEPTH);
          end else begin
            pending_length_nxt = item.send_length;
          end
          next_position_nxt = '0;
        end
      end
      bbuart_pkg::KIND_TICK: begin
        res_valid = 1'b1;
        if (pending_length_r == '0) begin
          // Idle tick: line and power pin follow the supplied level.
          power_hold_nxt = item.power_level;
          res.tx_line    = item.power_level;
          res.power_pin  = item.power_level;
          res.sending    = 1'b0;
        end else begin
          // Count down the frame, load the next byte, or end the send.
          if (bits_left_r != '0) begin
            bits_left_nxt = bits_left_r - 4'd1;
          end else if (next_position_r < pending_length_r) begin
            current_char_nxt  = store_rd_r;
            bits_left_nxt     = bbuart_pkg::FRAME_BITS;
            next_position_nxt = next_position_r + 6'd1;
          end else begin
            pending_length_nxt = '0;
            next_position_nxt  = '0;
          end
          // Start bit, stop level, or the data bit under the mask.
          if (bits_left_nxt >= bbuart_pkg::FRAME_BITS) begin
            res.tx_line  = 1'b0;
            bit_mask_nxt = bbuart_pkg::FIRST_MASK;
          end else if (bits_left_nxt == '0) begin
            res.tx_line = 1'b1;
          end else begin
            res.tx_line  = |(current_char_nxt & bit_mask_r);
            bit_mask_nxt = {bit_mask_r[6:0], 1'b0};
          end
          res.power_pin = power_hold_r;
          res.sending   = 1'b1;
        end
      end
      default: begin
        // Buffer writes and unused kinds leave the sequencer as is.
      end
    endcase
  end

  // Sequencer state, updated when an item leaves the input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_left_r      <= '0;
      current_char_r   <= '0;
      bit_mask_r       <= '0;
      next_position_r  <= '0;
      pending_length_r <= '0;
      power_hold_r     <= 1'b0;
    end else if (fire) begin
      bits_left_r      <= bits_left_nxt;
      current_char_r   <= current_char_nxt;
      bit_mask_r       <= bit_mask_nxt;
      next_position_r  <= next_position_nxt;
      pending_length_r <= pending_length_nxt;
      power_hold_r     <= power_hold_nxt;
    end
  end

endmodule

// ===== rtl/bitbang_uart_string_transmitter.sv =====
// Top level of the bit-banged UART string transmitter (8N1, one bit per tick).
// Depends on bbuart_pkg and bbuart_core.
//
// Usage: every input transfer carries a kind on in_tuser. A buffer write
// stores byte_value at byte_index; a start begins sending send_length bytes
// (saturated to the buffer depth) unless a send is already running; a tick
// is one bit time. Each tick yields exactly one output transfer holding the
// line level, the power pin and a sending flag; writes and starts yield none.
// A frame is a start bit, eight data bits LSB first and a stop bit; after
// the last byte one more stop-level tick is spent in the send.
// Path: an item is held in the input register, passes the sequencer, and
// its result is registered in the output register, which drives out_tvalid.
// Throughput: one item per cycle while the output is not stalled, set by
// the sequencer update between the input register and the output register.
// Reset clears the sequencer and both registers; buffer contents stay
// undefined until written. When the receiver stalls, the output register
// holds its result and the input register still takes one more item, after
// which in_tready falls until out_tready returns.
module bitbang_uart_string_transmitter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // byte_index[4:0], byte_value[12:5],
                                  // send_length[18:13], power_level[19], zero
  input  logic [1:0]  in_tuser,   // kind[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // tx_line[0], power_pin[1], sending[2], zero
);

  logic                in_valid_r;
  bbuart_pkg::item_t   item_r;
  logic                advance;
  logic                fire;
  logic                res_valid;
  bbuart_pkg::result_t res;
  logic                out_valid_r;
  bbuart_pkg::result_t out_r;

  // The output register frees when empty or taken this cycle.
  assign advance   = !out_valid_r || out_tready;
  assign fire      = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.kind        <= bbuart_pkg::kind_t'(in_tuser);
      item_r.byte_index  <= in_tdata[4:0];
      item_r.byte_value  <= in_tdata[12:5];
      item_r.send_length <= in_tdata[18:13];
      item_r.power_level <= in_tdata[19];
    end
  end

  bbuart_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .item      (item_r),
    .res_valid (res_valid),
    .res       (res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= fire && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_valid) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_r.sending, out_r.power_pin, out_r.tx_line};

endmodule
